[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the sine/cosine unit, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// checked on every rising edge of clk, switched off while rst_n is low
`define SCPU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked on every rising edge of clk, reset included
`define SCPU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`else

`define SCPU_ASSERT(lbl, prop, msg)
`define SCPU_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[rtl/core/scpu_pkg.sv]
// ----------------------------------------------------------------------------
// scpu_pkg
// constants and types for the fifth-order polynomial sine/cosine unit
// ----------------------------------------------------------------------------
package scpu_pkg;

    // phase resolution: a half turn is 2**HALF_TURN_BITS
    localparam int HALF_TURN_BITS = 24;
    localparam int PHASE_W        = HALF_TURN_BITS + 1;
    localparam int PROD_LSB       = 48 - HALF_TURN_BITS;
    localparam int PROD_MSB       = PROD_LSB + HALF_TURN_BITS;
    localparam int M_SHIFT        = 31 - HALF_TURN_BITS;

    localparam int ANGLE_W     = 32;
    localparam int PROD_W      = 63;
    localparam int M_W         = 31;
    localparam int FRAC_BITS   = 30;
    localparam int X_W         = 31;
    localparam int X2_W        = 32;
    localparam int X3_W        = 32;
    localparam int X5_W        = 34;
    localparam int C1X_W       = 61;
    localparam int NEGP_W      = 60;
    localparam int C5X_W       = 57;
    localparam int ACC_W       = 62;
    localparam int ROUND_SHIFT = 44;
    localparam int RND_W       = ACC_W + 1 - ROUND_SHIFT;
    localparam int MAG_W       = 17;
    localparam int VALUE_W     = 18;
    localparam int OUT_TDATA_W = 24;

    localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(1) << (HALF_TURN_BITS - 1);
    localparam logic [PHASE_W-1:0] HALF_TURN    = PHASE_W'(1) << HALF_TURN_BITS;

    // 2**32/pi and pi/2 in Q2.30
    localparam logic [30:0] INV_PI_Q32  = 31'd1367130551;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // polynomial coefficients, Q0.30
    localparam logic [29:0] COEF1_Q30 = 30'd1073414225;
    localparam logic [27:0] COEF3_Q30 = 28'd177886808;
    localparam logic [22:0] COEF5_Q30 = 23'd8067452;

    localparam logic [M_W-1:0]   ONE_Q30    = M_W'(1) << FRAC_BITS;
    localparam logic [MAG_W-1:0] ONE_Q16    = MAG_W'(1) << 16;
    localparam logic [ACC_W:0]   ROUND_HALF = (ACC_W + 1)'(1) << (ROUND_SHIFT - 1);

    // sideband that travels beside the data through the pipeline
    typedef struct packed {
        logic valid;
        logic neg;
    } scpu_tag_t;

endpackage

[rtl/core/sine_cosine_poly_unit.sv]
// ----------------------------------------------------------------------------
// sine_cosine_poly_unit
// sine or cosine of a Q16.16 radian angle, fifth-order odd polynomial, Q1.16 out
// ----------------------------------------------------------------------------
//  channel   dir  tdata                        tuser
//  s_axis    in   angle[31:0] signed Q16.16    kind[0] (0 sine, 1 cosine)
//  m_axis    out  value[17:0] signed Q1.16     -
//
//  one word in and one word out per cycle unless the output stalls; the
//  stages are angle scale, phase fold, six polynomial stages, sign and output register
//  the multiplier chain in scpu_poly sets the depth, up to two multiplies per stage
//  reset clears only the valid and sign tag bits; no state survives between words
//  a stalled output freezes the whole pipeline; nothing is dropped or repeated
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sine_cosine_poly_unit
    import scpu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [ANGLE_W-1:0]     s_axis_tdata,   // angle[31:0]
    input  logic                   s_axis_tuser,   // kind[0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // value[17:0], zero fill above
);

    logic en;

    logic                s1_valid_reg;
    logic                s1_kind_reg;
    logic [PHASE_W-1:0]  s1_phase_reg;
    scpu_tag_t           s2_tag_reg;
    logic [M_W-1:0]      s2_m_reg;
    logic                out_valid_reg;
    logic [VALUE_W-1:0]  value_reg;

    logic signed [PROD_W-1:0]  prod;
    logic [PHASE_W-1:0]        phase;
    logic [HALF_TURN_BITS-1:0] low;
    logic [HALF_TURN_BITS-1:0] m_raw;
    logic                      neg_t;
    scpu_tag_t                 s2_tag_next;
    logic [M_W-1:0]            s2_m_next;
    scpu_tag_t                 p_tag;
    logic [MAG_W-1:0]          p_mag;
    logic [VALUE_W-1:0]        value_next;

    // whole pipeline moves together unless the last word is held
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        prod = $signed(s_axis_tdata) * $signed({1'b0, INV_PI_Q32});

        // quarter turn offset, one more for cosine, wraps modulo a full turn
        phase = s1_phase_reg + (s1_kind_reg ? HALF_TURN : QUARTER_TURN);
        low   = phase[HALF_TURN_BITS-1:0];
        neg_t = !low[HALF_TURN_BITS-1];
        if (neg_t)
        begin
            m_raw = QUARTER_TURN[HALF_TURN_BITS-1:0] - low;
        end
        else
        begin
            m_raw = low - QUARTER_TURN[HALF_TURN_BITS-1:0];
        end
        s2_m_next         = {m_raw, {M_SHIFT{1'b0}}};
        s2_tag_next.valid = s1_valid_reg;
        // odd half-period flips the sign
        s2_tag_next.neg   = neg_t ^ phase[HALF_TURN_BITS];

        if (p_tag.neg)
        begin
            value_next = VALUE_W'(0) - VALUE_W'(p_mag);
        end
        else
        begin
            value_next = VALUE_W'(p_mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_tag_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= s_axis_tvalid;
            s2_tag_reg    <= s2_tag_next;
            out_valid_reg <= p_tag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_kind_reg  <= s_axis_tuser;
            s1_phase_reg <= prod[PROD_MSB:PROD_LSB];
            s2_m_reg     <= s2_m_next;
            value_reg    <= value_next;
        end
    end

    scpu_poly u_poly
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .tag_in  (s2_tag_reg),
        .m_in    (s2_m_reg),
        .tag_out (p_tag),
        .mag     (p_mag)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - VALUE_W)'(0), value_reg};

    `SCPU_ASSERT(a_no_take_in_stall, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready, "word taken in stall")
    `SCPU_ASSERT(a_take_enters, (s_axis_tvalid && s_axis_tready) |=> s1_valid_reg, "word lost at entry")
    `SCPU_ASSERT(a_m_in_range, s2_tag_reg.valid |-> (s2_m_reg <= ONE_Q30), "folded angle above one")
    `SCPU_ASSERT(a_value_in_range, m_axis_tvalid |-> (($signed(value_reg) <= $signed(VALUE_W'(ONE_Q16))) && ($signed(value_reg) >= -$signed(VALUE_W'(ONE_Q16)))), "value beyond one")
    `SCPU_ASSERT_ALWAYS(a_quiet_in_reset, !rst_n |-> !m_axis_tvalid, "output valid in reset")

endmodule

[rtl/core/scpu_poly.sv]
// ----------------------------------------------------------------------------
// scpu_poly
// six-stage evaluator of 0.9996949x - 0.16567x^3 + 0.0075134x^5 on |x| <= pi/2
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scpu_poly
    import scpu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  scpu_tag_t        tag_in,
    input  logic [M_W-1:0]   m_in,
    output scpu_tag_t        tag_out,
    output logic [MAG_W-1:0] mag
);

    scpu_tag_t tag_reg [6];

    logic [X_W-1:0]    x_reg;
    logic [X_W-1:0]    xd_reg;
    logic [X2_W-1:0]   x2_reg;
    logic [X2_W-1:0]   x2d_reg;
    logic [X3_W-1:0]   x3_reg;
    logic [X5_W-1:0]   x5_reg;
    logic [C1X_W-1:0]  c1x_reg;
    logic [C1X_W-1:0]  c1x_d_reg;
    logic [C1X_W-1:0]  c1x_d2_reg;
    logic [NEGP_W-1:0] negp_reg;
    logic [NEGP_W-1:0] negp_d_reg;
    logic [ACC_W-1:0]  pos_reg;
    logic [MAG_W-1:0]  mag_reg;

    logic [61:0]        x_prod;
    logic [61:0]        x2_prod;
    logic [62:0]        x3_prod;
    logic [63:0]        x5_prod;
    logic [C1X_W-1:0]   c1x_next;
    logic [NEGP_W-1:0]  negp_next;
    logic [C5X_W-1:0]   c5x_prod;
    logic [ACC_W-1:0]   pos_next;
    logic [ACC_W-1:0]   diff;
    logic [ACC_W:0]     rnd;
    logic [RND_W-1:0]   r;
    logic [MAG_W-1:0]   mag_next;

    always_comb
    begin
        x_prod    = 62'(m_in) * 62'(HALF_PI_Q30);
        x2_prod   = 62'(x_reg) * 62'(x_reg);
        c1x_next  = C1X_W'(COEF1_Q30) * C1X_W'(x_reg);
        x3_prod   = 63'(x2_reg) * 63'(xd_reg);
        x5_prod   = 64'(x3_reg) * 64'(x2d_reg);
        negp_next = NEGP_W'(COEF3_Q30) * NEGP_W'(x3_reg);
        c5x_prod  = C5X_W'(COEF5_Q30) * C5X_W'(x5_reg);
        pos_next  = ACC_W'(c1x_d2_reg) + ACC_W'(c5x_prod);

        // round half up from Q.60 to Q.16, clamp at one
        diff = pos_reg - ACC_W'(negp_d_reg);
        rnd  = (ACC_W + 1)'(diff) + ROUND_HALF;
        r    = rnd[ACC_W:ROUND_SHIFT];
        if (ACC_W'(negp_d_reg) >= pos_reg)
        begin
            mag_next = '0;
        end
        else if (r > RND_W'(ONE_Q16))
        begin
            mag_next = ONE_Q16;
        end
        else
        begin
            mag_next = r[MAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i < 6; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: x = m * pi/2
            x_reg      <= x_prod[FRAC_BITS+X_W-1:FRAC_BITS];
            // stage 2: x^2 and the linear term
            x2_reg     <= x2_prod[FRAC_BITS+X2_W-1:FRAC_BITS];
            xd_reg     <= x_reg;
            c1x_reg    <= c1x_next;
            // stage 3: x^3
            x3_reg     <= x3_prod[FRAC_BITS+X3_W-1:FRAC_BITS];
            x2d_reg    <= x2_reg;
            c1x_d_reg  <= c1x_reg;
            // stage 4: x^5 and the cubic term
            x5_reg     <= x5_prod[FRAC_BITS+X5_W-1:FRAC_BITS];
            negp_reg   <= negp_next;
            c1x_d2_reg <= c1x_d_reg;
            // stage 5: positive terms
            pos_reg    <= pos_next;
            negp_d_reg <= negp_reg;
            // stage 6: difference, rounding, clamp
            mag_reg    <= mag_next;
        end
    end

    assign tag_out = tag_reg[5];
    assign mag     = mag_reg;

    `SCPU_ASSERT(a_x_in_range, tag_reg[0].valid |-> (x_reg <= HALF_PI_Q30), "x beyond pi/2")
    `SCPU_ASSERT(a_mag_in_range, tag_reg[5].valid |-> (mag_reg <= ONE_Q16), "magnitude above one")
    `SCPU_ASSERT(a_hold_on_stall, !en |=> ($stable(mag_reg) && $stable(tag_reg[5])), "output moved in stall")

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// drives signed Q16.16 angles with a sine/cosine select into the polynomial
// unit and compares every Q1.16 result word against a bit-exact predictor
// ----------------------------------------------------------------------------
module tb_top
    import scpu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // fixed-point constants of the evaluation
    localparam longint unsigned RAD_TO_PHASE = 64'd1367130551;   // round(2^32/pi)
    localparam longint unsigned HALF_PI_FX   = 64'd1686629713;   // pi/2 in Q2.30
    localparam longint unsigned C1_FX        = 64'd1073414225;
    localparam longint unsigned C3_FX        = 64'd177886808;
    localparam longint unsigned C5_FX        = 64'd8067452;
    localparam longint unsigned UNITY_Q16    = 64'd65536;

    localparam logic KIND_SINE   = 1'b0;
    localparam logic KIND_COSINE = 1'b1;

    // angles in Q16.16 radians
    localparam int ANG_HALF_PI = 102944;
    localparam int ANG_PI      = 205887;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b1;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [ANGLE_W-1:0]     s_axis_tdata = '0;     // angle[31:0]
    logic                   s_axis_tuser = 1'b0;   // kind[0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;          // value[17:0], zero fill above

    int src_idle_pct  = 35;
    int sink_idle_pct = 82;
    int mismatch_count = 0;

    logic [VALUE_W-1:0] expected_values[$];
    logic [VALUE_W-1:0] value_exp;

    sine_cosine_poly_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #(5_000_000);
        $display("tb_top: errors");
        $finish;
    end

    // bit-exact sine/cosine of one angle, returned as the 18-bit result field
    function automatic logic [VALUE_W-1:0] sine_cosine_value(logic kind, logic [31:0] angle);
        longint          ang;
        longint unsigned prod;
        longint unsigned phase;
        longint unsigned low;
        longint unsigned m;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned x3;
        longint unsigned x5;
        longint unsigned pos;
        longint unsigned negp;
        longint unsigned mag;
        longint unsigned quarter;
        logic            neg_t;
        logic            odd_half;
        ang     = longint'($signed(angle));
        prod    = longint'(ang * longint'(RAD_TO_PHASE));
        quarter = 64'd1 << (HALF_TURN_BITS - 1);
        phase   = (prod >> (48 - HALF_TURN_BITS)) + quarter;
        if (kind)
            phase = phase + quarter;
        phase    = phase & ((64'd1 << (HALF_TURN_BITS + 1)) - 1);
        odd_half = phase[HALF_TURN_BITS];
        low      = phase & ((64'd1 << HALF_TURN_BITS) - 1);
        neg_t    = (low < quarter);
        m        = neg_t ? (quarter - low) : (low - quarter);
        m        = m << (31 - HALF_TURN_BITS);
        x    = (m * HALF_PI_FX) >> 30;
        x2   = (x * x) >> 30;
        x3   = (x2 * x) >> 30;
        x5   = (x3 * x2) >> 30;
        pos  = C1_FX * x + C5_FX * x5;
        negp = C3_FX * x3;
        if (negp >= pos)
            mag = 0;
        else
            mag = (pos - negp + (64'd1 << 43)) >> 44;
        if (mag > UNITY_Q16)
            mag = UNITY_Q16;
        if (neg_t != odd_half)
            mag = 64'd0 - mag;
        return mag[VALUE_W-1:0];
    endfunction

    // result side: check each accepted word, then pick next cycle's tready
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_values.size() == 0)
            begin
                $error("unexpected word: value %0d", $signed(m_axis_tdata[VALUE_W-1:0]));
                mismatch_count++;
            end
            else
            begin
                value_exp = expected_values.pop_front();
                if (m_axis_tdata[VALUE_W-1:0] !== value_exp)
                begin
                    $error("value: expected %0d actual %0d", $signed(value_exp),
                           $signed(m_axis_tdata[VALUE_W-1:0]));
                    mismatch_count++;
                end
                if (m_axis_tdata[OUT_TDATA_W-1:VALUE_W] !== '0)
                begin
                    $error("fill: expected 0 actual %0h", m_axis_tdata[OUT_TDATA_W-1:VALUE_W]);
                    mismatch_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // present one word and hold it until taken; tvalid stays high afterwards
    task automatic send_angle(logic kind, logic [31:0] angle);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tuser  <= 1'($urandom_range(1));
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= angle;
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_values.push_back(sine_cosine_value(kind, angle));
    endtask

    task automatic send_random_angles(int count);
        int   sel;
        int   ang;
        logic kind;
        for (int i = 0; i < count; i++)
        begin
            sel  = $urandom_range(99);
            kind = 1'($urandom_range(1));
            if (sel < 55)
                ang = $urandom;
            else if (sel < 80)
                ang = $urandom_range(8 * ANG_PI) - 4 * ANG_PI;
            else
                // close to a multiple of a quarter turn, where the fold changes
                ang = ($urandom_range(40) - 20) * ANG_HALF_PI + $urandom_range(128) - 64;
            send_angle(kind, ang);
        end
    endtask

    task automatic test_range_extremes();
        send_angle(KIND_SINE, 32'h0000_0000);
        send_angle(KIND_COSINE, 32'h0000_0000);
        send_angle(KIND_SINE, 32'h7FFF_FFFF);
        send_angle(KIND_COSINE, 32'h7FFF_FFFF);
        send_angle(KIND_SINE, 32'h8000_0000);
        send_angle(KIND_COSINE, 32'h8000_0000);
        send_angle(KIND_SINE, 32'h0000_0001);
        send_angle(KIND_SINE, 32'hFFFF_FFFF);
    endtask

    task automatic test_quadrant_axes();
        send_angle(KIND_SINE, ANG_HALF_PI);
        send_angle(KIND_SINE, -ANG_HALF_PI);
        send_angle(KIND_SINE, ANG_PI);
        send_angle(KIND_SINE, -ANG_PI);
        send_angle(KIND_COSINE, ANG_PI);
        send_angle(KIND_COSINE, 3 * ANG_HALF_PI);
    endtask

    // the polynomial peaks just over one near a quarter turn
    task automatic test_saturation_edge();
        send_angle(KIND_SINE, ANG_HALF_PI - 1);
        send_angle(KIND_SINE, ANG_HALF_PI + 1);
        send_angle(KIND_SINE, -ANG_HALF_PI - 1);
        send_angle(KIND_SINE, -ANG_HALF_PI + 1);
        send_angle(KIND_COSINE, 32'h0000_0001);
        send_angle(KIND_COSINE, 32'hFFFF_FFFF);
    endtask

    task automatic test_stalled_sink();
        src_idle_pct  = 35;
        sink_idle_pct = 82;
        send_random_angles(285);
    endtask

    task automatic test_sparse_source();
        src_idle_pct  = 82;
        sink_idle_pct = 35;
        send_random_angles(285);
    endtask

    task automatic test_back_to_back();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_random_angles(285);
    endtask

    initial
    begin
        // a real falling edge, so the asynchronous reset takes hold at once
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_range_extremes();
        test_quadrant_axes();
        test_saturation_edge();
        test_stalled_sink();
        test_sparse_source();
        test_back_to_back();

        s_axis_tvalid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
